@@ hw/rtl/sspd_pkg.sv @@
// Package for the servo status packet deframer.
// Holds the phase type, action and status codes, config indexes and the result struct.
// No dependencies.
`default_nettype none

package sspd_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_HUNT_LIMIT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

  localparam logic [7:0]  HUNT_LIMIT_RESET    = 8'd50;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADSUM  = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_NOHDR   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  localparam logic KIND_PARAM   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HUNT1,
    PH_HUNT2,
    PH_ID,
    PH_LEN,
    PH_ERR,
    PH_PARAM,
    PH_CHK
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] unit_id;
    logic [7:0] data_byte;
    logic [7:0] param_index;
    logic [7:0] param_count;
    logic [2:0] status;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/sspd_core.sv @@
// Deframer state and the per-transaction update logic.
// Takes one registered transaction per enabled cycle and yields at most one result.
// Depends on sspd_pkg.
`default_nettype none

module sspd_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [1:0]          action,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [7:0]          hunt_limit,
  input  wire logic [15:0]         timeout_ticks,
  output logic                     has_result,
  output sspd_pkg::result_t        result
);
  import sspd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  hunt_attempts, hunt_attempts_next;
  logic [15:0] silent_ticks, silent_ticks_next;
  logic [7:0]  packet_id, packet_id_next;
  logic [7:0]  packet_length, packet_length_next;
  logic [7:0]  servo_error, servo_error_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  param_position, param_position_next;

  logic [7:0]  limit;
  logic [7:0]  attempts_inc;
  logic [15:0] ticks_inc;
  logic [7:0]  count_params;

  always_comb begin
    limit        = (hunt_limit == 8'd0) ? 8'd1 : hunt_limit;
    attempts_inc = (hunt_attempts == 8'hFF) ? hunt_attempts : hunt_attempts + 8'd1;
    ticks_inc    = (silent_ticks == 16'hFFFF) ? silent_ticks : silent_ticks + 16'd1;
    count_params = (packet_length < MIN_LENGTH) ? 8'd0 : packet_length - MIN_LENGTH;

    phase_next          = phase;
    hunt_attempts_next  = hunt_attempts;
    silent_ticks_next   = silent_ticks;
    packet_id_next      = packet_id;
    packet_length_next  = packet_length;
    servo_error_next    = servo_error;
    bytes_left_next     = bytes_left;
    running_sum_next    = running_sum;
    param_position_next = param_position;

    has_result         = 1'b0;
    result.kind        = KIND_VERDICT;
    result.unit_id     = packet_id;
    result.data_byte   = servo_error;
    result.param_index = 8'd0;
    result.param_count = count_params;
    result.status      = ST_OK;

    if (action == ACT_START) begin
      phase_next          = PH_HUNT1;
      hunt_attempts_next  = 8'd0;
      silent_ticks_next   = 16'd0;
      packet_id_next      = 8'd0;
      packet_length_next  = 8'd0;
      servo_error_next    = 8'd0;
      bytes_left_next     = 8'd0;
      running_sum_next    = 8'd0;
      param_position_next = 8'd0;
    end else if (phase != PH_IDLE && action == ACT_TICK) begin
      silent_ticks_next = ticks_inc;
      if (ticks_inc >= timeout_ticks) begin
        has_result    = 1'b1;
        result.status = ST_TIMEOUT;
        phase_next    = PH_IDLE;
      end
    end else if (phase != PH_IDLE && action == ACT_BYTE) begin
      silent_ticks_next = 16'd0;
      unique case (phase)
        PH_HUNT1, PH_HUNT2: begin
          if (rx_byte == HDR_BYTE) begin
            phase_next = (phase == PH_HUNT1) ? PH_HUNT2 : PH_ID;
          end else begin
            hunt_attempts_next = attempts_inc;
            if (attempts_inc >= limit) begin
              has_result    = 1'b1;
              result.status = ST_NOHDR;
              phase_next    = PH_IDLE;
            end else begin
              phase_next = PH_HUNT1;
            end
          end
        end
        PH_ID: begin
          packet_id_next   = rx_byte;
          running_sum_next = rx_byte;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          packet_length_next = rx_byte;
          if (rx_byte < MIN_LENGTH) begin
            has_result         = 1'b1;
            result.status      = ST_SHORT;
            result.param_count = 8'd0;
            phase_next         = PH_IDLE;
          end else begin
            running_sum_next    = running_sum + rx_byte;
            bytes_left_next     = rx_byte - MIN_LENGTH;
            param_position_next = 8'd0;
            phase_next          = PH_ERR;
          end
        end
        PH_ERR: begin
          servo_error_next = rx_byte;
          running_sum_next = running_sum + rx_byte;
          phase_next       = (bytes_left != 8'd0) ? PH_PARAM : PH_CHK;
        end
        PH_PARAM: begin
          running_sum_next    = running_sum + rx_byte;
          has_result          = 1'b1;
          result.kind         = KIND_PARAM;
          result.data_byte    = rx_byte;
          result.param_index  = param_position;
          param_position_next = param_position + 8'd1;
          bytes_left_next     = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_CHK;
          end
        end
        PH_CHK: begin
          has_result    = 1'b1;
          result.status = (rx_byte == ~running_sum) ? ST_OK : ST_BADSUM;
          phase_next    = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      hunt_attempts  <= 8'd0;
      silent_ticks   <= 16'd0;
      packet_id      <= 8'd0;
      packet_length  <= 8'd0;
      servo_error    <= 8'd0;
      bytes_left     <= 8'd0;
      running_sum    <= 8'd0;
      param_position <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      hunt_attempts  <= hunt_attempts_next;
      silent_ticks   <= silent_ticks_next;
      packet_id      <= packet_id_next;
      packet_length  <= packet_length_next;
      servo_error    <= servo_error_next;
      bytes_left     <= bytes_left_next;
      running_sum    <= running_sum_next;
      param_position <= param_position_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/servo_status_packet_deframer.sv @@
// A transaction is held in the input register until the core steps on it; the result that it
// yields is then registered in the output register, out_q, which drives the result ports.
// Throughput: one transaction per cycle; while a result waits, one more transaction is taken
// into the input register and the input then stalls until the result is taken.
// Reset clears the deframer to idle and loads hunt_limit 50 and timeout_ticks 1000.
// Depends on sspd_pkg and sspd_core.
`default_nettype none

module servo_status_packet_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [sspd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sspd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      action,
  input  wire logic [7:0]                      rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 kind,
  output logic [7:0]                           unit_id,
  output logic [7:0]                           data_byte,
  output logic [7:0]                           param_index,
  output logic [7:0]                           param_count,
  output logic [2:0]                           status
);
  import sspd_pkg::*;

  logic [7:0]  hunt_limit;
  logic [15:0] timeout_ticks;

  logic        held_valid;
  logic [1:0]  held_action;
  logic [7:0]  held_byte;

  logic        step;
  logic        has_result;
  result_t     result;
  result_t     out_q;

  assign step     = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_limit    <= HUNT_LIMIT_RESET;
      timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HUNT_LIMIT:    hunt_limit    <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_action <= action;
      held_byte   <= rx_byte;
    end
  end

  sspd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .action        (held_action),
    .rx_byte       (held_byte),
    .hunt_limit    (hunt_limit),
    .timeout_ticks (timeout_ticks),
    .has_result    (has_result),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      out_q <= result;
    end
  end

  assign kind        = out_q.kind;
  assign unit_id     = out_q.unit_id;
  assign data_byte   = out_q.data_byte;
  assign param_index = out_q.param_index;
  assign param_count = out_q.param_count;
  assign status      = out_q.status;

endmodule

`default_nettype wire

@@ dv/servo_status_packet_deframer_tb.sv @@
// Testbench for servo_status_packet_deframer: directed and random serial streams are checked
// against a packet predictor kept inside the bench, under random stalls and register changes.
// Depends on sspd_pkg and the deframer RTL.
`timescale 1ns / 100ps

module servo_status_packet_deframer_tb;
  import sspd_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_COUNT = 8;

  typedef struct {
    logic [1:0] act;
    logic [7:0] b;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [7:0] unit_id;
  logic [7:0] data_byte;
  logic [7:0] param_index;
  logic [7:0] param_count;
  logic [2:0] status;

  // Predictor state and its copy of the registers.
  phase_t ph;
  logic [7:0] attempts;
  logic [15:0] quiet;
  logic [7:0] pkt_id;
  logic [7:0] pkt_len;
  logic [7:0] srv_err;
  logic [7:0] left;
  logic [7:0] sum;
  logic [7:0] pos;
  logic [7:0] hunt_cfg;
  logic [15:0] tmo_cfg;

  result_t awaited_results[$];
  result_t front;
  int errors = 0;
  int items_taken = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int idle_run = 0;
  bit long_pending = 1'b0;

  logic [7:0] hunt_plan [PHASE_COUNT] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd50, 8'd2, 8'd255, 8'd1};
  logic [15:0] tick_plan [PHASE_COUNT] =
    '{16'd1, 16'd65535, 16'd0, 16'd12, 16'd1000, 16'd5, 16'd1, 16'd65535};
  int send_plan [PHASE_COUNT] = '{0, 64, 0, 20, 0, 64, 0, 20};
  int recv_plan [PHASE_COUNT] = '{0, 0, 64, 20, 0, 0, 64, 20};
  stim_row_t directed_rows [27];

  servo_status_packet_deframer DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .unit_id(unit_id),
    .data_byte(data_byte),
    .param_index(param_index),
    .param_count(param_count),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (seen !== want)
      report_error($sformatf("%s expected 0x%02h got 0x%02h", name, want, seen));
  endtask

  function automatic logic [7:0] param_total();
    return (pkt_len < MIN_LENGTH) ? 8'd0 : pkt_len - MIN_LENGTH;
  endfunction

  function automatic result_t close_packet(input logic [2:0] st);
    result_t v;
    v.kind = KIND_VERDICT;
    v.unit_id = pkt_id;
    v.data_byte = srv_err;
    v.param_index = 8'd0;
    v.param_count = param_total();
    v.status = st;
    ph = PH_IDLE;
    return v;
  endfunction

  task automatic fail_attempt(output bit got, output result_t r);
    logic [7:0] lim;
    lim = (hunt_cfg == 8'd0) ? 8'd1 : hunt_cfg;
    got = 1'b0;
    r = '0;
    if (attempts != 8'hFF) attempts++;
    ph = PH_HUNT1;
    if (attempts >= lim) begin
      got = 1'b1;
      r = close_packet(ST_NOHDR);
    end
  endtask

  task automatic predict_deframe(input logic [1:0] act, input logic [7:0] b,
                                 output bit got, output result_t r);
    got = 1'b0;
    r = '0;
    if (act == ACT_START) begin
      ph = PH_HUNT1;
      attempts = 8'd0;
      quiet = 16'd0;
      pkt_id = 8'd0;
      pkt_len = 8'd0;
      srv_err = 8'd0;
      left = 8'd0;
      sum = 8'd0;
      pos = 8'd0;
    end else if (ph == PH_IDLE || act == ACT_UNUSED) begin
      got = 1'b0;
    end else if (act == ACT_TICK) begin
      if (quiet != 16'hFFFF) quiet++;
      if (quiet >= tmo_cfg) begin
        got = 1'b1;
        r = close_packet(ST_TIMEOUT);
      end
    end else begin
      quiet = 16'd0;
      case (ph)
        PH_HUNT1, PH_HUNT2: begin
          if (b == HDR_BYTE) ph = (ph == PH_HUNT1) ? PH_HUNT2 : PH_ID;
          else fail_attempt(got, r);
        end
        PH_ID: begin
          pkt_id = b;
          sum = b;
          ph = PH_LEN;
        end
        PH_LEN: begin
          pkt_len = b;
          if (b < MIN_LENGTH) begin
            got = 1'b1;
            r = close_packet(ST_SHORT);
          end else begin
            sum = sum + b;
            left = b - MIN_LENGTH;
            pos = 8'd0;
            ph = PH_ERR;
          end
        end
        PH_ERR: begin
          srv_err = b;
          sum = sum + b;
          ph = (left != 8'd0) ? PH_PARAM : PH_CHK;
        end
        PH_PARAM: begin
          sum = sum + b;
          got = 1'b1;
          r.kind = KIND_PARAM;
          r.unit_id = pkt_id;
          r.data_byte = b;
          r.param_index = pos;
          r.param_count = param_total();
          r.status = ST_OK;
          pos++;
          left--;
          if (left == 8'd0) ph = PH_CHK;
        end
        default: begin
          got = 1'b1;
          r = close_packet((b == ~sum) ? ST_OK : ST_BADSUM);
        end
      endcase
    end
  endtask

  // Entered and left just after a falling edge.
  task automatic offer(input logic [1:0] act, input logic [7:0] b,
                       input bit typed = 1'b0, input result_t want = '0);
    bit got;
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_START || (ph != PH_IDLE && (act == ACT_BYTE || act == ACT_TICK)))
      items_taken++;
    predict_deframe(act, b, got, r);
    if (got) awaited_results.insert(awaited_results.size(), typed ? want : r);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_HUNT_LIMIT) hunt_cfg = val[7:0];
    else tmo_cfg = val;
    @(negedge clk);
  endtask

  task automatic settle();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame();
    logic [7:0] body [$];
    logic [7:0] pkt_sum;
    logic [7:0] len;
    logic [7:0] b;
    int n;
    int cut;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) offer(2'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    offer(ACT_START, 8'($urandom_range(255)));
    if ($urandom_range(99) < 25) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(1) == 1) offer(ACT_BYTE, HDR_BYTE);
        offer(ACT_BYTE, 8'($urandom_range(254)));
      end
    end
    n = $urandom_range(99);
    if (long_pending) len = 8'd255;
    else if (n < 5) len = 8'($urandom_range(1));
    else if (n < 8) len = 8'($urandom_range(11, 60));
    else len = 8'($urandom_range(2, 8));
    body.insert(body.size(), HDR_BYTE);
    body.insert(body.size(), HDR_BYTE);
    body.insert(body.size(), 8'($urandom_range(255)));
    body.insert(body.size(), len);
    pkt_sum = body[2] + len;
    if (len >= MIN_LENGTH) begin
      repeat (len - 1) begin
        b = 8'($urandom_range(255));
        pkt_sum = pkt_sum + b;
        body.insert(body.size(), b);
      end
      if ($urandom_range(99) < 80) body.insert(body.size(), ~pkt_sum);
      else body.insert(body.size(), 8'($urandom_range(255)));
    end
    cut = body.size();
    if (!long_pending && $urandom_range(99) < 10) cut = $urandom_range(body.size() - 1);
    long_pending = 1'b0;
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(99) < 3) offer(ACT_TICK, 8'($urandom_range(255)));
      offer(ACT_BYTE, body[i]);
    end
    if (cut < body.size()) begin
      if (tmo_cfg == 16'd0) n = 1;
      else if (tmo_cfg <= 16'd40) n = int'(tmo_cfg);
      else n = $urandom_range(1, 4);
      repeat (n) offer(ACT_TICK, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_error($sformatf("unexpected result kind %0d id 0x%02h data 0x%02h status %0d",
                               kind, unit_id, data_byte, status));
      end else begin
        front = awaited_results.pop_front();
        check_field("kind", 8'(front.kind), 8'(kind));
        check_field("unit_id", front.unit_id, unit_id);
        check_field("data_byte", front.data_byte, data_byte);
        check_field("param_index", front.param_index, param_index);
        check_field("param_count", front.param_count, param_count);
        check_field("status", 8'(front.status), 8'(status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int phase_end;
    directed_rows = '{
      '{ACT_BYTE, 8'h12, 1'b0, '0},
      '{ACT_TICK, 8'h00, 1'b0, '0},
      '{ACT_START, 8'h00, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b0, '0},
      '{ACT_BYTE, 8'hFE, 1'b0, '0},
      '{ACT_BYTE, 8'h02, 1'b0, '0},
      '{ACT_BYTE, 8'h00, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b1, '{KIND_VERDICT, 8'hFE, 8'h00, 8'h00, 8'h00, ST_OK}},
      '{ACT_START, 8'hFF, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b0, '0},
      '{ACT_BYTE, 8'h01, 1'b0, '0},
      '{ACT_BYTE, 8'h01, 1'b1, '{KIND_VERDICT, 8'h01, 8'h00, 8'h00, 8'h00, ST_SHORT}},
      '{ACT_START, 8'h00, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b0, '0},
      '{ACT_START, 8'hA5, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b0, '0},
      '{ACT_TICK, 8'hFF, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b0, '0},
      '{ACT_UNUSED, 8'h55, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b0, '0},
      '{ACT_BYTE, 8'h04, 1'b0, '0},
      '{ACT_BYTE, 8'h80, 1'b0, '0},
      '{ACT_BYTE, 8'h00, 1'b0, '0},
      '{ACT_BYTE, 8'hFF, 1'b0, '0},
      '{ACT_BYTE, 8'h00, 1'b1, '{KIND_VERDICT, 8'hFF, 8'h80, 8'h00, 8'h02, ST_BADSUM}}
    };
    ph = PH_IDLE;
    attempts = 8'd0;
    quiet = 16'd0;
    pkt_id = 8'd0;
    pkt_len = 8'd0;
    srv_err = 8'd0;
    left = 8'd0;
    sum = 8'd0;
    pos = 8'd0;
    hunt_cfg = HUNT_LIMIT_RESET;
    tmo_cfg = TIMEOUT_TICKS_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer(directed_rows[i].act, directed_rows[i].b, directed_rows[i].typed,
            directed_rows[i].want);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      in_valid <= 1'b0;
      settle();
      write_reg(CFG_HUNT_LIMIT, {8'($urandom_range(255)), hunt_plan[p]});
      write_reg(CFG_TIMEOUT_TICKS, tick_plan[p]);
      send_idle_pct = send_plan[p];
      recv_stall_pct = recv_plan[p];
      long_pending = (p == 1);
      if (p == 3) hold_cycles = 300;
      phase_end = items_taken + 100;
      while (items_taken < phase_end) send_frame();
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ servo_status_packet_deframer.f @@
hw/rtl/sspd_pkg.sv
hw/rtl/sspd_core.sv
hw/rtl/servo_status_packet_deframer.sv
dv/servo_status_packet_deframer_tb.sv
